// ----- hdl/cpbd_pkg.sv -----
// cpbd_pkg: shared types, constants and widths of the centre peak box decoder
`default_nettype none
package cpbd_pkg;

	localparam int CELL_STRIDE = 4;

	localparam int SCORE_W   = 16;
	localparam int FIELD_W   = 16;
	localparam int CELL_W    = 8;
	localparam int IMG_W     = 12;
	localparam int NET_W     = 11;
	localparam int INV_W     = 24;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 24;

	localparam int CELL_FRAC = 9;
	localparam int FRAC      = 25;
	localparam int IMG_SHIFT = 24;
	localparam int NET_SHIFT = 8;

	localparam int POS_W  = 20;
	localparam int P_W    = POS_W + $clog2(CELL_STRIDE) + 1;
	localparam int PROD_W = P_W + INV_W + 1;
	localparam int SUM_W  = PROD_W + 1;
	localparam int EDGE_W = SUM_W - FRAC;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = QPTR_W + 1;

	localparam logic [SCORE_W-1:0] THRESHOLD_RST = 16'd19661;
	localparam logic [IMG_W-1:0]   IMG_W_RST     = 12'd640;
	localparam logic [IMG_W-1:0]   IMG_H_RST     = 12'd480;
	localparam logic [NET_W-1:0]   NET_W_RST     = 11'd512;
	localparam logic [NET_W-1:0]   NET_H_RST     = 11'd512;
	localparam logic [INV_W-1:0]   INV_RST       = 24'd81920;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_THRESHOLD = 3'd0,
		REG_IMG_WIDTH = 3'd1,
		REG_IMG_HEIGHT = 3'd2,
		REG_NET_WIDTH = 3'd3,
		REG_NET_HEIGHT = 3'd4,
		REG_INV_SCALE = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [SCORE_W-1:0] score_threshold;
		logic [IMG_W-1:0]   image_width;
		logic [IMG_W-1:0]   image_height;
		logic [NET_W-1:0]   net_width;
		logic [NET_W-1:0]   net_height;
		logic [INV_W-1:0]   inverse_scale;
	} cfg_t;

	// edge positions in net pixels, image centre not yet added
	typedef struct packed {
		logic signed [P_W-1:0] xl;
		logic signed [P_W-1:0] xr;
		logic signed [P_W-1:0] yt;
		logic signed [P_W-1:0] yb;
	} edge_pos_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage
`default_nettype wire

// ----- hdl/center_peak_box_decode_top.sv -----
// center_peak_box_decode_top: top level of the centre peak box decoder
// Takes one heatmap cell per clock while in_ready is high and, for a cell
// that is a local peak above score_threshold, returns its box in source image
// pixels, clipped to the image; cells that are not peaks or whose clipped box
// has no area give no result. Throughput is one item per cycle while the output
// is not stalled, set by the four parallel edge multipliers of the back pipeline.
// A kept cell goes through a four-entry queue and a four-stage back pipeline
// (queue read, multiply, centre add and truncate, clip into the output register).
// in_ready drops only while the queue is full. Registers are written through
// cfg_wen, cfg_index and cfg_data and should be changed only while the block
// is empty.
`default_nettype none
module center_peak_box_decode_top (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_wen,
	input  wire logic [cpbd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [cpbd_pkg::CFG_DAT_W-1:0]      cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [cpbd_pkg::SCORE_W-1:0]        peak_score,
	input  wire logic [cpbd_pkg::SCORE_W-1:0]        pooled_score,
	input  wire logic signed [cpbd_pkg::FIELD_W-1:0] offset_x,
	input  wire logic signed [cpbd_pkg::FIELD_W-1:0] offset_y,
	input  wire logic signed [cpbd_pkg::FIELD_W-1:0] box_w,
	input  wire logic signed [cpbd_pkg::FIELD_W-1:0] box_h,
	input  wire logic [cpbd_pkg::CELL_W-1:0]         cell_col,
	input  wire logic [cpbd_pkg::CELL_W-1:0]         cell_row,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic [cpbd_pkg::IMG_W-1:0]               box_left,
	output logic [cpbd_pkg::IMG_W-1:0]               box_top,
	output logic [cpbd_pkg::IMG_W-1:0]               box_width,
	output logic [cpbd_pkg::IMG_W-1:0]               box_height
);
	import cpbd_pkg::*;

	cfg_t           cfg_q;
	logic           push, pop;
	edge_pos_t      push_data, pop_data;
	queue_status_t  qstat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.score_threshold <= THRESHOLD_RST;
			cfg_q.image_width     <= IMG_W_RST;
			cfg_q.image_height    <= IMG_H_RST;
			cfg_q.net_width       <= NET_W_RST;
			cfg_q.net_height      <= NET_H_RST;
			cfg_q.inverse_scale   <= INV_RST;
		end else if (cfg_wen) begin
			case (cfg_reg_t'(cfg_index))
				REG_THRESHOLD:  cfg_q.score_threshold <= cfg_data[SCORE_W-1:0];
				REG_IMG_WIDTH:  cfg_q.image_width     <= cfg_data[IMG_W-1:0];
				REG_IMG_HEIGHT: cfg_q.image_height    <= cfg_data[IMG_W-1:0];
				REG_NET_WIDTH:  cfg_q.net_width       <= cfg_data[NET_W-1:0];
				REG_NET_HEIGHT: cfg_q.net_height      <= cfg_data[NET_W-1:0];
				REG_INV_SCALE:  cfg_q.inverse_scale   <= cfg_data[INV_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_ready = !qstat.full;

	cpbd_front u_front (
		.accept       (in_valid && in_ready),
		.cfg          (cfg_q),
		.peak_score   (peak_score),
		.pooled_score (pooled_score),
		.offset_x     (offset_x),
		.offset_y     (offset_y),
		.box_w        (box_w),
		.box_h        (box_h),
		.cell_col     (cell_col),
		.cell_row     (cell_row),
		.push         (push),
		.entry        (push_data)
	);

	cpbd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.status    (qstat)
	);

	cpbd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.qstat      (qstat),
		.q_data     (pop_data),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.box_left   (box_left),
		.box_top    (box_top),
		.box_width  (box_width),
		.box_height (box_height)
	);

endmodule
`default_nettype wire

// ----- hdl/cpbd_front.sv -----
// cpbd_front: peak test and edge positions of one heatmap cell
`default_nettype none
module cpbd_front (
	input  wire logic                           accept,
	input  wire cpbd_pkg::cfg_t                 cfg,
	input  wire logic [cpbd_pkg::SCORE_W-1:0]   peak_score,
	input  wire logic [cpbd_pkg::SCORE_W-1:0]   pooled_score,
	input  wire logic signed [cpbd_pkg::FIELD_W-1:0] offset_x,
	input  wire logic signed [cpbd_pkg::FIELD_W-1:0] offset_y,
	input  wire logic signed [cpbd_pkg::FIELD_W-1:0] box_w,
	input  wire logic signed [cpbd_pkg::FIELD_W-1:0] box_h,
	input  wire logic [cpbd_pkg::CELL_W-1:0]    cell_col,
	input  wire logic [cpbd_pkg::CELL_W-1:0]    cell_row,
	output logic                                push,
	output cpbd_pkg::edge_pos_t                 entry
);
	import cpbd_pkg::*;

	logic                    kept;
	logic signed [POS_W-1:0] cx, cy;
	logic signed [P_W-1:0]   net_x, net_y;

	function automatic logic signed [P_W-1:0] to_net(input logic signed [POS_W-1:0] pos,
		input logic signed [P_W-1:0] net_half);
		logic signed [P_W-1:0] pos_e;
		pos_e = P_W'(pos);
		return P_W'(pos_e * CELL_STRIDE) - net_half;
	endfunction

	always_comb begin
		kept = (peak_score == pooled_score) && (pooled_score > cfg.score_threshold);
		push = accept && kept;

		// centre in cells with nine fraction bits
		cx = $signed(POS_W'({cell_col, {CELL_FRAC{1'b0}}}))
			+ (POS_W'(offset_x) <<< 1);
		cy = $signed(POS_W'({cell_row, {CELL_FRAC{1'b0}}}))
			+ (POS_W'(offset_y) <<< 1);

		net_x = $signed(P_W'({cfg.net_width, {NET_SHIFT{1'b0}}}));
		net_y = $signed(P_W'({cfg.net_height, {NET_SHIFT{1'b0}}}));

		entry.xl = to_net(cx - POS_W'(box_w), net_x);
		entry.xr = to_net(cx + POS_W'(box_w), net_x);
		entry.yt = to_net(cy - POS_W'(box_h), net_y);
		entry.yb = to_net(cy + POS_W'(box_h), net_y);
	end

endmodule
`default_nettype wire

// ----- hdl/cpbd_queue.sv -----
// cpbd_queue: short queue of kept cells between front and back
`default_nettype none
module cpbd_queue (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire cpbd_pkg::edge_pos_t  push_data,
	input  wire logic                 pop,
	output cpbd_pkg::edge_pos_t       pop_data,
	output cpbd_pkg::queue_status_t   status
);
	import cpbd_pkg::*;

	edge_pos_t          mem_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;

	function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ptr_next(wr_ptr_q);
			if (pop)
				rd_ptr_q <= ptr_next(rd_ptr_q);
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	assign pop_data     = mem_q[rd_ptr_q];
	assign status.full  = (count_q == QCNT_W'(QDEPTH));
	assign status.empty = (count_q == '0);

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && status.full && !pop)) else $error("item pushed into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && status.empty)) else $error("item popped from empty queue");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count did not follow push");
`endif

endmodule
`default_nettype wire

// ----- hdl/cpbd_back.sv -----
// cpbd_back: scaling, truncation and clipping pipeline with output register
`default_nettype none
module cpbd_back (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire cpbd_pkg::cfg_t             cfg,
	input  wire cpbd_pkg::queue_status_t    qstat,
	input  wire cpbd_pkg::edge_pos_t        q_data,
	output logic                            pop,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic [cpbd_pkg::IMG_W-1:0]      box_left,
	output logic [cpbd_pkg::IMG_W-1:0]      box_top,
	output logic [cpbd_pkg::IMG_W-1:0]      box_width,
	output logic [cpbd_pkg::IMG_W-1:0]      box_height
);
	import cpbd_pkg::*;

	localparam logic signed [SUM_W-1:0] ONE  = SUM_W'(1) <<< FRAC;
	localparam logic signed [SUM_W-1:0] BIAS = ONE - SUM_W'(1);

	logic                     adv;
	logic                     valid_s1, valid_s2, valid_s3;
	edge_pos_t                pos_s1;
	logic signed [PROD_W-1:0] xl_s2, xr_s2, yt_s2, yb_s2;
	logic signed [EDGE_W-1:0] xl_s3, xr_s3, yt_s3, yb_s3;
	logic signed [PROD_W-1:0] inv_s;
	logic signed [SUM_W-1:0]  cen_x, cen_y;
	logic [2*IMG_W:0]         x_res, y_res;
	logic                     out_valid_q;
	logic [IMG_W-1:0]         box_left_q, box_top_q, box_width_q, box_height_q;

	// add centre, optional one, truncate toward zero
	function automatic logic signed [EDGE_W-1:0] finish(input logic signed [PROD_W-1:0] prod,
		input logic signed [SUM_W-1:0] cen, input logic plus_one);
		logic signed [SUM_W-1:0] s, t;
		s = SUM_W'(prod) + cen + (plus_one ? ONE : '0);
		t = s + (s[SUM_W-1] ? BIAS : '0);
		return t[SUM_W-1:FRAC];
	endfunction

	// order, clip to [0, lim], report {positive, start, size}
	function automatic logic [2*IMG_W:0] clip_axis(input logic signed [EDGE_W-1:0] a,
		input logic signed [EDGE_W-1:0] b, input logic [IMG_W-1:0] lim);
		logic signed [EDGE_W-1:0] lo, hi, lim_s, diff;
		lim_s = $signed(EDGE_W'(lim));
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		if (lo < 0)
			lo = '0;
		if (hi > lim_s)
			hi = lim_s;
		diff = hi - lo;
		return {hi > lo, lo[IMG_W-1:0], diff[IMG_W-1:0]};
	endfunction

	assign adv = !out_valid_q || out_ready;
	assign pop = adv && !qstat.empty;

	always_comb begin
		inv_s = $signed(PROD_W'(cfg.inverse_scale));
		cen_x = $signed(SUM_W'({cfg.image_width, {IMG_SHIFT{1'b0}}}));
		cen_y = $signed(SUM_W'({cfg.image_height, {IMG_SHIFT{1'b0}}}));
		x_res = clip_axis(xl_s3, xr_s3, cfg.image_width);
		y_res = clip_axis(yt_s3, yb_s3, cfg.image_height);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= pop;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			out_valid_q <= valid_s3 && x_res[2*IMG_W] && y_res[2*IMG_W];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pos_s1       <= q_data;
			xl_s2        <= PROD_W'(pos_s1.xl) * inv_s;
			xr_s2        <= PROD_W'(pos_s1.xr) * inv_s;
			yt_s2        <= PROD_W'(pos_s1.yt) * inv_s;
			yb_s2        <= PROD_W'(pos_s1.yb) * inv_s;
			xl_s3        <= finish(xl_s2, cen_x, 1'b0);
			xr_s3        <= finish(xr_s2, cen_x, 1'b1);
			yt_s3        <= finish(yt_s2, cen_y, 1'b0);
			yb_s3        <= finish(yb_s2, cen_y, 1'b1);
			box_left_q   <= x_res[2*IMG_W-1:IMG_W];
			box_width_q  <= x_res[IMG_W-1:0];
			box_top_q    <= y_res[2*IMG_W-1:IMG_W];
			box_height_q <= y_res[IMG_W-1:0];
		end
	end

	assign out_valid  = out_valid_q;
	assign box_left   = box_left_q;
	assign box_top    = box_top_q;
	assign box_width  = box_width_q;
	assign box_height = box_height_q;

`ifndef NO_ASSERTIONS
	a_area_positive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (box_width_q != '0 && box_height_q != '0))
		else $error("box with no area presented");
`endif

endmodule
`default_nettype wire

// ----- test/tb_top.sv -----
// tb_top: self-checking testbench for the centre peak box decoder top level
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
	import cpbd_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

	typedef struct packed {
		logic [SCORE_W-1:0]        peak_score;
		logic [SCORE_W-1:0]        pooled_score;
		logic signed [FIELD_W-1:0] offset_x;
		logic signed [FIELD_W-1:0] offset_y;
		logic signed [FIELD_W-1:0] box_w;
		logic signed [FIELD_W-1:0] box_h;
		logic [CELL_W-1:0]         cell_col;
		logic [CELL_W-1:0]         cell_row;
	} cell_t;

	typedef struct packed {
		logic [IMG_W-1:0] left;
		logic [IMG_W-1:0] top;
		logic [IMG_W-1:0] width;
		logic [IMG_W-1:0] height;
	} box_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_wen = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [IMG_W-1:0]     box_left;
	logic [IMG_W-1:0]     box_top;
	logic [IMG_W-1:0]     box_width;
	logic [IMG_W-1:0]     box_height;

	cell_t sent_cell = '0;
	cfg_t  active_cfg = '{THRESHOLD_RST, IMG_W_RST, IMG_H_RST, NET_W_RST, NET_H_RST, INV_RST};
	cell_t cells_to_send[$];
	box_t  expected_boxes[$];
	int    err_count = 0;
	int    gap_left = 0;
	int    stall_left = 0;
	int    hold_req = 0;
	int    hold_seen = 0;
	bit    send_idle = 1'b1;
	bit    recv_idle = 1'b1;

	center_peak_box_decode_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wen      (cfg_wen),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.peak_score   (sent_cell.peak_score),
		.pooled_score (sent_cell.pooled_score),
		.offset_x     (sent_cell.offset_x),
		.offset_y     (sent_cell.offset_y),
		.box_w        (sent_cell.box_w),
		.box_h        (sent_cell.box_h),
		.cell_col     (sent_cell.cell_col),
		.cell_row     (sent_cell.cell_row),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.box_left     (box_left),
		.box_top      (box_top),
		.box_width    (box_width),
		.box_height   (box_height)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// one edge in image pixels, truncated toward zero
	function automatic longint edge_to_pixel(input longint pos_q9, input longint net,
			input longint img, input longint inv, input longint bump);
		longint v;
		v = (pos_q9 * CELL_STRIDE - net * 256) * inv + (img <<< 24) + bump;
		return (v >= 0) ? (v >>> 25) : -((-v) >>> 25);
	endfunction

	function automatic bit decode_cell(input cell_t c, input cfg_t k, output box_t b);
		longint unit, cx, cy, bw, bh, xl, xr, yt, yb, lo_x, hi_x, lo_y, hi_y;
		longint img_w, img_h, inv;
		b = '0;
		if (c.peak_score != c.pooled_score || c.pooled_score <= k.score_threshold)
			return 1'b0;
		unit = longint'(1) <<< 25;
		img_w = longint'(k.image_width);
		img_h = longint'(k.image_height);
		inv = longint'(k.inverse_scale);
		bw = longint'($signed(c.box_w));
		bh = longint'($signed(c.box_h));
		cx = longint'(c.cell_col) * 512 + longint'($signed(c.offset_x)) * 2;
		cy = longint'(c.cell_row) * 512 + longint'($signed(c.offset_y)) * 2;
		xl = edge_to_pixel(cx - bw, longint'(k.net_width), img_w, inv, 0);
		xr = edge_to_pixel(cx + bw, longint'(k.net_width), img_w, inv, unit);
		yt = edge_to_pixel(cy - bh, longint'(k.net_height), img_h, inv, 0);
		yb = edge_to_pixel(cy + bh, longint'(k.net_height), img_h, inv, unit);
		lo_x = (xl < xr) ? xl : xr;
		hi_x = (xl > xr) ? xl : xr;
		lo_y = (yt < yb) ? yt : yb;
		hi_y = (yt > yb) ? yt : yb;
		if (lo_x < 0) lo_x = 0;
		if (lo_y < 0) lo_y = 0;
		if (hi_x > img_w) hi_x = img_w;
		if (hi_y > img_h) hi_y = img_h;
		if (hi_x <= lo_x || hi_y <= lo_y)
			return 1'b0;
		b.left = lo_x[IMG_W-1:0];
		b.top = lo_y[IMG_W-1:0];
		b.width = IMG_W'(hi_x - lo_x);
		b.height = IMG_W'(hi_y - lo_y);
		return 1'b1;
	endfunction

	// mostly short pauses, now and then a long one
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 8);
		return $urandom_range(15, 40);
	endfunction

	function automatic cell_t make_cell(input int peak, input int pooled, input int ox,
			input int oy, input int bw, input int bh, input int col, input int row);
		cell_t c;
		c.peak_score = SCORE_W'(peak);
		c.pooled_score = SCORE_W'(pooled);
		c.offset_x = FIELD_W'(ox);
		c.offset_y = FIELD_W'(oy);
		c.box_w = FIELD_W'(bw);
		c.box_h = FIELD_W'(bh);
		c.cell_col = CELL_W'(col);
		c.cell_row = CELL_W'(row);
		return c;
	endfunction

	function automatic cell_t random_cell();
		cell_t c;
		int kind, max_col, max_row, thr, sz;
		c = make_cell($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom);
		kind = $urandom_range(0, 99);
		thr = int'(active_cfg.score_threshold);
		if (kind < 70) begin
			// a well-formed peak with a box near the cell
			max_col = int'(active_cfg.net_width) / CELL_STRIDE;
			max_row = int'(active_cfg.net_height) / CELL_STRIDE;
			if (max_col > 255) max_col = 255;
			if (max_row > 255) max_row = 255;
			c.cell_col = CELL_W'($urandom_range(0, max_col));
			c.cell_row = CELL_W'($urandom_range(0, max_row));
			c.offset_x = FIELD_W'(int'($urandom_range(0, 511)) - 256);
			c.offset_y = FIELD_W'(int'($urandom_range(0, 511)) - 256);
			sz = $urandom_range(0, 40 * 256);
			if ($urandom_range(0, 9) == 0) sz = -sz;
			c.box_w = FIELD_W'(sz);
			sz = $urandom_range(0, 40 * 256);
			if ($urandom_range(0, 9) == 0) sz = -sz;
			c.box_h = FIELD_W'(sz);
			if (thr < 65535)
				c.pooled_score = SCORE_W'($urandom_range(thr + 1, 65535));
			c.peak_score = c.pooled_score;
		end else if (kind < 85) begin
			c.peak_score = c.pooled_score;
		end else if (kind >= 93) begin
			// right on the threshold, or not quite a peak
			c.pooled_score = SCORE_W'(thr);
			c.peak_score = $urandom_range(0, 1) ? SCORE_W'(thr) : SCORE_W'(thr ^ 1);
		end
		return c;
	endfunction

	task automatic report_error(input string msg);
		err_count++;
		if (err_count <= 100)
			$display("%0t ns: %s", $time, msg);
	endtask

	task automatic add_cell(input cell_t c);
		cells_to_send.insert(cells_to_send.size(), c);
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin
		cell_t next_cell;
		box_t  box;
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left <= 0;
		end else begin
			if (in_valid && in_ready) begin
				if (decode_cell(sent_cell, active_cfg, box))
					expected_boxes.insert(expected_boxes.size(), box);
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (cells_to_send.size() > 0) begin
					next_cell = cells_to_send.pop_front();
					sent_cell <= next_cell;
					in_valid <= 1'b1;
					gap_left <= (send_idle && $urandom_range(0, 3) == 0) ? idle_len() : 0;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin
		box_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left <= 0;
			hold_seen <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_boxes.size() == 0) begin
					report_error($sformatf("box %0d,%0d %0dx%0d with no kept cell pending",
						box_left, box_top, box_width, box_height));
				end else begin
					want = expected_boxes.pop_front();
					if (box_left !== want.left)
						report_error($sformatf("box_left %0d, want %0d", box_left, want.left));
					if (box_top !== want.top)
						report_error($sformatf("box_top %0d, want %0d", box_top, want.top));
					if (box_width !== want.width)
						report_error($sformatf("box_width %0d, want %0d", box_width, want.width));
					if (box_height !== want.height)
						report_error($sformatf("box_height %0d, want %0d", box_height,
							want.height));
				end
			end
			if (hold_req != hold_seen) begin
				hold_seen <= hold_req;
				stall_left <= 80;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				out_ready <= 1'b0;
			end else if (recv_idle && $urandom_range(0, 9) < 2) begin
				stall_left <= idle_len() - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DAT_W'(value);
		@(posedge clk);
		cfg_wen <= 1'b0;
		case (idx)
			REG_THRESHOLD:  active_cfg.score_threshold = SCORE_W'(value);
			REG_IMG_WIDTH:  active_cfg.image_width = IMG_W'(value);
			REG_IMG_HEIGHT: active_cfg.image_height = IMG_W'(value);
			REG_NET_WIDTH:  active_cfg.net_width = NET_W'(value);
			REG_NET_HEIGHT: active_cfg.net_height = NET_W'(value);
			REG_INV_SCALE:  active_cfg.inverse_scale = INV_W'(value);
			default: ;
		endcase
	endtask

	task automatic write_all(input int thr, input int img_w, input int img_h,
			input int net_w, input int net_h, input int unsigned inv);
		write_reg(REG_THRESHOLD, thr);
		write_reg(REG_IMG_WIDTH, img_w);
		write_reg(REG_IMG_HEIGHT, img_h);
		write_reg(REG_NET_WIDTH, net_w);
		write_reg(REG_NET_HEIGHT, net_h);
		write_reg(REG_INV_SCALE, inv);
	endtask

	// block empty and every kept cell's box seen, then pipeline flush time
	task automatic wait_drained();
		do @(negedge clk);
		while (cells_to_send.size() != 0 || in_valid || expected_boxes.size() != 0);
		repeat (12) @(negedge clk);
	endtask

	task automatic send_random_cells(input int n);
		@(negedge clk);
		repeat (n) add_cell(random_cell());
		wait_drained();
	endtask

	initial begin
		int img_w, img_h, net_w, net_h;
		longint inv;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: scores, extremes and box shapes
		add_cell(make_cell(30000, 30000, 0, 0, 2560, 2560, 64, 64));
		add_cell(make_cell(30000, 29999, 0, 0, 2560, 2560, 64, 64));
		add_cell(make_cell(19661, 19661, 0, 0, 2560, 2560, 64, 64));
		add_cell(make_cell(19662, 19662, 0, 0, 2560, 2560, 64, 64));
		add_cell(make_cell(40000, 40000, 128, -128, -2560, -1280, 60, 50));
		add_cell(make_cell(40000, 40000, 0, 0, 0, 0, 64, 48));
		add_cell(make_cell(65535, 65535, 32767, 32767, 32767, 32767, 255, 255));
		add_cell(make_cell(65535, 65535, -32768, -32768, -32768, -32768, 0, 0));
		add_cell(make_cell(0, 0, 0, 0, 0, 0, 0, 0));
		add_cell(make_cell(50000, 50000, 0, 0, 512, 512, 255, 0));
		add_cell(make_cell(50000, 50000, 0, 0, 2048, 2048, 0, 0));
		add_cell(make_cell(50000, 50000, 0, 0, 32767, 32767, 64, 64));
		add_cell(make_cell(50000, 50000, 32767, -32768, 256, 256, 64, 64));
		add_cell(make_cell(50000, 50000, -256, 255, 512, 512, 127, 127));
		add_cell(make_cell(16'hAAAA, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
			16'h2AAA, 8'hAA, 8'h55));
		add_cell(make_cell(16'h5555, 16'h5555, 16'hAAAA, 16'h5555, 16'h2AAA,
			16'h5555, 8'h55, 8'hAA));
		wait_drained();
		send_random_cells(100);

		// large image, lowest threshold
		write_all(0, 4095, 4095, 1024, 1024, 262080);
		send_random_cells(120);

		// highest threshold: nothing is kept
		write_all(16'hFFFF, 1, 1, 4, 4, 24'hFFFFFF);
		send_random_cells(30);

		// zero inverse scale: left and top edges land on the image centre, right and bottom one pixel past it
		write_all(1000, 640, 480, 512, 512, 0);
		@(negedge clk);
		add_cell(make_cell(30000, 30000, 0, 0, 2560, 2560, 64, 64));
		add_cell(make_cell(30000, 30000, 0, 0, -2560, 0, 0, 255));
		add_cell(make_cell(30000, 30000, 32767, -32768, 0, 0, 255, 0));
		wait_drained();
		send_random_cells(60);

		// zero image size: clipping leaves no area
		write_all(1000, 0, 0, 2047, 4, 81920);
		@(negedge clk);
		add_cell(make_cell(30000, 30000, 0, 0, 2560, 2560, 0, 0));
		add_cell(make_cell(30000, 30000, 0, 0, 32767, 32767, 128, 1));
		wait_drained();
		send_random_cells(60);

		// network sizes outside their nominal range, spare register index
		write_all(0, 4095, 1, 0, 2047, 24'hFFFFFF);
		write_reg(REG_SPARE, 24'h5A5A5A);
		send_random_cells(100);

		repeat (4) begin
			img_w = $urandom_range(1, 4095);
			img_h = $urandom_range(1, 4095);
			net_w = CELL_STRIDE * $urandom_range(1, 256);
			net_h = CELL_STRIDE * $urandom_range(1, 256);
			inv = (longint'(img_w) * 65536 / net_w) * $urandom_range(80, 120) / 100;
			if (inv < 1) inv = 1;
			if (inv > 24'hFFFFFF) inv = 24'hFFFFFF;
			write_all($urandom_range(0, 40000), img_w, img_h, net_w, net_h, int'(inv));
			send_random_cells(100);
		end

		// receiver holds off while cells keep coming
		write_all(10000, 640, 480, 512, 512, 81920);
		@(negedge clk);
		send_idle = 1'b0;
		hold_req = hold_req + 1;
		send_random_cells(60);

		// no idling on either side
		recv_idle = 1'b0;
		send_random_cells(60);

		if (err_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin
		#6_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
`default_nettype wire

// ----- sim.f -----
hdl/cpbd_pkg.sv
hdl/cpbd_front.sv
hdl/cpbd_queue.sv
hdl/cpbd_back.sv
hdl/center_peak_box_decode_top.sv
test/tb_top.sv
